[src/htw_pkg.sv]
// shared types and constants of the hierarchical timer wheel
package htw_pkg;

  localparam int SLOT_W = 6;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } htw_op_t;

  localparam logic [KIND_W-1:0] EV_ADDED   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REJECT  = 2'd1;
  localparam logic [KIND_W-1:0] EV_EXPIRED = 2'd2;
  localparam logic [KIND_W-1:0] EV_IDLE    = 2'd3;

  typedef struct packed {
    htw_op_t             op;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   expire;
    logic [TIME_W-1:0]   data;
    logic [TIME_W-1:0]   now;
  } htw_item_t;

endpackage

[src/htw_front.sv]
// front end: classifies incoming transactions into a two-entry queue
module htw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               hold,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [5:0]         slot,
  input  logic [31:0]        expire_time,
  input  logic [31:0]        timer_data,
  input  logic [31:0]        now_time,
  output logic               q_valid,
  input  logic               q_ready,
  output htw_pkg::htw_item_t q_item
);
  import htw_pkg::*;

  htw_item_t  items [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  htw_item_t  new_item;

  assign in_ready = (count != 2'd2) && !hold;
  assign q_valid  = (count != 2'd0);
  assign q_item   = items[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    new_item.op     = func ? OP_TICK : OP_ADD;
    new_item.slot   = slot;
    new_item.expire = expire_time;
    new_item.data   = timer_data;
    new_item.now    = now_time;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr] <= new_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[src/htw_back.sv]
// back end: bucket and slot memories, list walking sequencer and result register
module htw_back #(
  parameter int POOL_SLOTS = 64,
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  htw_pkg::htw_item_t q_item,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_kind,
  output logic [5:0]         out_slot,
  output logic [31:0]        out_data,
  output logic               last
);
  import htw_pkg::*;

  localparam int SW         = $clog2(POOL_SLOTS);
  localparam int ROOT_SIZE  = 1 << ROOT_BITS;
  localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
  localparam int NBKT       = ROOT_SIZE + 4 * LEVEL_SIZE;
  localparam int BW         = $clog2(NBKT);
  localparam int BE_W       = 1 + 2 * SW;
  localparam int SH1        = ROOT_BITS;
  localparam int SH2        = ROOT_BITS + LEVEL_BITS;
  localparam int SH3        = ROOT_BITS + 2 * LEVEL_BITS;
  localparam int SH4        = ROOT_BITS + 3 * LEVEL_BITS;
  localparam int L1_BASE    = ROOT_SIZE;
  localparam int L2_BASE    = ROOT_SIZE + LEVEL_SIZE;
  localparam int L3_BASE    = ROOT_SIZE + 2 * LEVEL_SIZE;
  localparam int L4_BASE    = ROOT_SIZE + 3 * LEVEL_SIZE;
  localparam logic [SLOT_W:0] POOL_LIM = (SLOT_W + 1)'(POOL_SLOTS);
  localparam logic [BW-1:0]   CLR_END  = BW'(NBKT - 1);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_EMIT     = 12'b000000000100,
    S_FILE_RD  = 12'b000000001000,
    S_FILE_WR  = 12'b000000010000,
    S_CAS_RD   = 12'b000000100000,
    S_CAS_CHK  = 12'b000001000000,
    S_WALK_RD  = 12'b000010000000,
    S_ROOT_RD  = 12'b000100000000,
    S_ROOT_CHK = 12'b001000000000,
    S_EXP_RD   = 12'b010000000000,
    S_EXP_EMIT = 12'b100000000000
  } state_t;

  state_t                  state;
  logic [TIME_W-1:0]       wt;
  logic [SW-1:0]           cur;
  logic [TIME_W-1:0]       cur_exp;
  logic [SW-1:0]           walk_tail;
  logic [SW-1:0]           nxt;
  logic [BW-1:0]           fbkt;
  logic                    from_add;
  logic [1:0]              lv;
  logic [ROOT_BITS-1:0]    root_idx;
  logic [POOL_SLOTS-1:0]   pending;
  logic [BW-1:0]           clr_cnt;
  logic [KIND_W-1:0]       res_kind;
  logic [SLOT_W-1:0]       res_slot;

  // memories
  logic [BE_W-1:0]   bkt_mem [NBKT];
  logic [SW-1:0]     snx_mem [POOL_SLOTS];
  logic [TIME_W-1:0] exp_mem [POOL_SLOTS];
  logic [TIME_W-1:0] wrd_mem [POOL_SLOTS];

  logic              bkt_we, bkt_re, snx_we, snx_re, exp_re, wrd_re, add_we;
  logic [BW-1:0]     bkt_waddr, bkt_raddr;
  logic [BE_W-1:0]   bkt_wdata, bkt_rdata;
  logic [SW-1:0]     snx_waddr, snx_wdata, snx_rdata;
  logic [TIME_W-1:0] exp_rdata, wrd_rdata;

  logic [SW-1:0]     b_head, b_tail;
  logic              b_ne;
  logic [TIME_W-1:0] exp_val, span, tick_dist;
  logic [BW-1:0]     file_bkt, cas_bkt, root_bkt;
  logic [LEVEL_BITS-1:0] dig;
  logic              out_free;
  logic              emit_go;
  logic              in_range, reject;
  logic [SW-1:0]     in_idx;

  assign b_ne      = bkt_rdata[BE_W-1];
  assign b_head    = bkt_rdata[2*SW-1:SW];
  assign b_tail    = bkt_rdata[SW-1:0];
  assign out_free  = !out_valid || out_ready;
  assign emit_go   = ((state == S_EMIT) || (state == S_EXP_EMIT)) && out_free;
  assign clearing  = (state == S_CLEAR);
  assign q_ready   = (state == S_IDLE);
  assign in_idx    = q_item.slot[SW-1:0];
  assign in_range  = {1'b0, q_item.slot} < POOL_LIM;
  assign reject    = !in_range || pending[in_idx];
  assign tick_dist = q_item.now - wt;
  assign root_bkt  = BW'(root_idx);
  assign add_we    = (state == S_IDLE) && q_valid && (q_item.op == OP_ADD) && !reject;

  // bucket choice for filing
  always_comb begin
    exp_val = from_add ? cur_exp : exp_rdata;
    span    = exp_val - wt;
    if ((span >> SH1) == '0) begin
      file_bkt = BW'(exp_val[ROOT_BITS-1:0]);
    end else if ((span >> SH2) == '0) begin
      file_bkt = BW'(L1_BASE) + BW'(exp_val[SH1 +: LEVEL_BITS]);
    end else if ((span >> SH3) == '0) begin
      file_bkt = BW'(L2_BASE) + BW'(exp_val[SH2 +: LEVEL_BITS]);
    end else if ((span >> SH4) == '0) begin
      file_bkt = BW'(L3_BASE) + BW'(exp_val[SH3 +: LEVEL_BITS]);
    end else if (span[TIME_W-1]) begin
      file_bkt = BW'(wt[ROOT_BITS-1:0]);
    end else begin
      file_bkt = BW'(L4_BASE) + BW'(exp_val[SH4 +: LEVEL_BITS]);
    end
  end

  // bucket of the level being cascaded
  always_comb begin
    case (lv)
      2'd0: begin
        dig     = wt[SH1 +: LEVEL_BITS];
        cas_bkt = BW'(L1_BASE) + BW'(dig);
      end
      2'd1: begin
        dig     = wt[SH2 +: LEVEL_BITS];
        cas_bkt = BW'(L2_BASE) + BW'(dig);
      end
      2'd2: begin
        dig     = wt[SH3 +: LEVEL_BITS];
        cas_bkt = BW'(L3_BASE) + BW'(dig);
      end
      default: begin
        dig     = wt[SH4 +: LEVEL_BITS];
        cas_bkt = BW'(L4_BASE) + BW'(dig);
      end
    endcase
  end

  // memory port control
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = fbkt;
    bkt_wdata = '0;
    bkt_re    = 1'b0;
    bkt_raddr = file_bkt;
    snx_we    = 1'b0;
    snx_waddr = b_tail;
    snx_wdata = cur;
    snx_re    = 1'b0;
    exp_re    = 1'b0;
    wrd_re    = 1'b0;
    case (state)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_cnt;
      end
      S_FILE_RD: begin
        bkt_re = 1'b1;
      end
      S_FILE_WR: begin
        bkt_we = 1'b1;
        if (b_ne) begin
          bkt_wdata = {1'b1, b_head, cur};
          snx_we    = 1'b1;
        end else begin
          bkt_wdata = {1'b1, cur, cur};
        end
      end
      S_CAS_RD: begin
        bkt_re    = 1'b1;
        bkt_raddr = cas_bkt;
      end
      S_ROOT_RD: begin
        bkt_re    = 1'b1;
        bkt_raddr = root_bkt;
      end
      S_CAS_CHK, S_ROOT_CHK: begin
        bkt_we = b_ne;
      end
      S_WALK_RD: begin
        snx_re = 1'b1;
        exp_re = 1'b1;
      end
      S_EXP_RD: begin
        snx_re = 1'b1;
        wrd_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rdata <= bkt_mem[bkt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (snx_we) begin
      snx_mem[snx_waddr] <= snx_wdata;
    end
    if (snx_re) begin
      snx_rdata <= snx_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (add_we) begin
      exp_mem[in_idx] <= q_item.expire;
      wrd_mem[in_idx] <= q_item.data;
    end
    if (exp_re) begin
      exp_rdata <= exp_mem[cur];
    end
    if (wrd_re) begin
      wrd_rdata <= wrd_mem[cur];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      wt        <= '0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BW'(1);
          if (clr_cnt == CLR_END) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_ADD) begin
              res_slot <= q_item.slot;
              if (reject) begin
                res_kind <= EV_REJECT;
                state    <= S_EMIT;
              end else begin
                pending[in_idx] <= 1'b1;
                cur             <= in_idx;
                cur_exp         <= q_item.expire;
                from_add        <= 1'b1;
                state           <= S_FILE_RD;
              end
            end else if (tick_dist[TIME_W-1]) begin
              res_kind <= EV_IDLE;
              res_slot <= '0;
              state    <= S_EMIT;
            end else begin
              root_idx <= wt[ROOT_BITS-1:0];
              if (wt[ROOT_BITS-1:0] == '0) begin
                lv    <= 2'd0;
                state <= S_CAS_RD;
              end else begin
                wt    <= wt + TIME_W'(1);
                state <= S_ROOT_RD;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            event_kind <= res_kind;
            out_slot   <= res_slot;
            out_data   <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_FILE_RD: begin
          fbkt  <= file_bkt;
          nxt   <= snx_rdata;
          state <= S_FILE_WR;
        end
        S_FILE_WR: begin
          if (from_add) begin
            res_kind <= EV_ADDED;
            state    <= S_EMIT;
          end else if (cur != walk_tail) begin
            cur   <= nxt;
            state <= S_WALK_RD;
          end else if (dig == '0 && lv != 2'd3) begin
            lv    <= lv + 2'd1;
            state <= S_CAS_RD;
          end else begin
            wt    <= wt + TIME_W'(1);
            state <= S_ROOT_RD;
          end
        end
        S_CAS_RD: begin
          fbkt  <= cas_bkt;
          state <= S_CAS_CHK;
        end
        S_CAS_CHK: begin
          if (b_ne) begin
            cur       <= b_head;
            walk_tail <= b_tail;
            from_add  <= 1'b0;
            state     <= S_WALK_RD;
          end else if (dig == '0 && lv != 2'd3) begin
            lv    <= lv + 2'd1;
            state <= S_CAS_RD;
          end else begin
            wt    <= wt + TIME_W'(1);
            state <= S_ROOT_RD;
          end
        end
        S_WALK_RD: begin
          state <= S_FILE_RD;
        end
        S_ROOT_RD: begin
          fbkt  <= root_bkt;
          state <= S_ROOT_CHK;
        end
        S_ROOT_CHK: begin
          if (b_ne) begin
            cur       <= b_head;
            walk_tail <= b_tail;
            state     <= S_EXP_RD;
          end else begin
            res_kind <= EV_IDLE;
            res_slot <= '0;
            state    <= S_EMIT;
          end
        end
        S_EXP_RD: begin
          state <= S_EXP_EMIT;
        end
        S_EXP_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            event_kind   <= EV_EXPIRED;
            out_slot     <= SLOT_W'(cur);
            out_data     <= wrd_rdata;
            last         <= (cur == walk_tail);
            pending[cur] <= 1'b0;
            if (cur == walk_tail) begin
              state <= S_IDLE;
            end else begin
              cur   <= snx_rdata;
              state <= S_EXP_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/hierarchical_timer_wheel.sv]
// top level of the five-level hierarchical timer wheel
// Input channel (in_valid/in_ready): func 0 adds timer slot with expire_time
// and timer_data, func 1 is a tick carrying now_time. Output channel
// (out_valid/out_ready) returns event_kind, out_slot, out_data and last; last
// marks the final result of each input transaction.
// A transaction is registered in the input queue before it reaches the sequencer.
// An add reads and then rewrites its bucket before its result is registered; a
// rejected add goes straight to the result register. A tick that has not reached
// wheel time gives one idle result, as does one that advances the wheel but
// expires nothing. A tick that expires slots gives one result per slot,
// walking the root bucket list through the slot memories one entry at a time.
// When the root index wraps, each level visited has its current bucket read
// and every slot in it filed again by its remaining distance to expiry.
// A two-entry input queue takes transactions while the sequencer works.
// After reset the bucket memory is cleared in one pass over its 2^ROOT_BITS +
// 4 * 2^LEVEL_BITS buckets (512 by default); no input is taken meanwhile.
// When the receiver stalls, the result register holds and the sequencer
// waits; the input queue keeps filling until full.
module hierarchical_timer_wheel #(
  parameter int POOL_SLOTS = 64,
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [5:0]  slot,
  input  logic [31:0] expire_time,
  input  logic [31:0] timer_data,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [5:0]  out_slot,
  output logic [31:0] out_data,
  output logic        last
);
  import htw_pkg::*;

  htw_item_t q_item;
  logic      q_valid;
  logic      q_ready;
  logic      clearing;

  htw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (clearing),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .slot        (slot),
    .expire_time (expire_time),
    .timer_data  (timer_data),
    .now_time    (now_time),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  htw_back #(
    .POOL_SLOTS (POOL_SLOTS),
    .ROOT_BITS  (ROOT_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .out_slot   (out_slot),
    .out_data   (out_data),
    .last       (last)
  );

endmodule

[dv/htw_checker.sv]
// checker of the timer wheel: predicts results from accepted inputs and compares
`timescale 1ns / 100ps
module htw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [5:0]  slot,
  input  logic [31:0] expire_time,
  input  logic [31:0] timer_data,
  input  logic [31:0] now_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  event_kind,
  input  logic [5:0]  out_slot,
  input  logic [31:0] out_data,
  input  logic        last,
  output int          errors,
  output int          checked,
  output int          waiting
);
  import htw_pkg::*;

  localparam int ROOT_SIZE = 256;
  localparam int LEVEL_SIZE = 64;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] sl;
    logic [31:0]       data;
    logic              fin;
  } timer_event_t;

  timer_event_t      events_due[$];
  logic [31:0]       wheel_now;
  logic [5:0]        head_of[512];
  logic [5:0]        tail_of[512];
  logic              filled[512];
  logic [5:0]        link_of[64];
  logic [31:0]       expiry_of[64];
  logic [31:0]       word_of[64];
  logic              armed[64];

  assign waiting = events_due.size();

  function automatic int level_bucket(int lv, logic [31:0] i);
    return ROOT_SIZE + (lv - 1) * LEVEL_SIZE + int'(i[5:0]);
  endfunction

  task automatic chain_slot(int b, logic [5:0] s);
    if (filled[b]) begin
      link_of[tail_of[b]] = s;
      tail_of[b] = s;
    end else begin
      head_of[b] = s;
      tail_of[b] = s;
      filled[b] = 1'b1;
    end
  endtask

  task automatic place_slot(logic [5:0] s);
    logic [31:0] e;
    logic [31:0] d;
    int b;
    e = expiry_of[s];
    d = e - wheel_now;
    if (d < 32'd256) b = int'(e[7:0]);
    else if (d < (32'd1 << 14)) b = level_bucket(1, e >> 8);
    else if (d < (32'd1 << 20)) b = level_bucket(2, e >> 14);
    else if (d < (32'd1 << 26)) b = level_bucket(3, e >> 20);
    else if (d[31]) b = int'(wheel_now[7:0]);
    else b = level_bucket(4, e >> 26);
    chain_slot(b, s);
  endtask

  task automatic unchain(int b, ref logic [5:0] lst[$]);
    logic [5:0] cur;
    lst = {};
    if (filled[b]) begin
      cur = head_of[b];
      while (lst.size() < 64) begin
        lst.push_back(cur);
        if (cur == tail_of[b]) break;
        cur = link_of[cur];
      end
      filled[b] = 1'b0;
    end
  endtask

  task automatic push_down(int lv, logic [31:0] i);
    logic [5:0] lst[$];
    unchain(level_bucket(lv, i), lst);
    foreach (lst[k]) place_slot(lst[k]);
  endtask

  task automatic predict_item();
    logic [5:0] lst[$];
    logic [31:0] d;
    int idx;
    if (htw_op_t'(func) == OP_ADD) begin
      if (armed[slot]) begin
        events_due.push_back('{EV_REJECT, slot, 32'd0, 1'b1});
      end else begin
        expiry_of[slot] = expire_time;
        word_of[slot] = timer_data;
        armed[slot] = 1'b1;
        place_slot(slot);
        events_due.push_back('{EV_ADDED, slot, 32'd0, 1'b1});
      end
    end else begin
      d = now_time - wheel_now;
      if (d[31]) begin
        events_due.push_back('{EV_IDLE, 6'd0, 32'd0, 1'b1});
      end else begin
        idx = int'(wheel_now[7:0]);
        if (idx == 0) begin
          push_down(1, wheel_now >> 8);
          if (wheel_now[13:8] == 6'd0) begin
            push_down(2, wheel_now >> 14);
            if (wheel_now[19:14] == 6'd0) begin
              push_down(3, wheel_now >> 20);
              if (wheel_now[25:20] == 6'd0) push_down(4, wheel_now >> 26);
            end
          end
        end
        wheel_now = wheel_now + 32'd1;
        unchain(idx, lst);
        if (lst.size() == 0) begin
          events_due.push_back('{EV_IDLE, 6'd0, 32'd0, 1'b1});
        end else begin
          foreach (lst[k]) begin
            armed[lst[k]] = 1'b0;
            events_due.push_back('{EV_EXPIRED, lst[k], word_of[lst[k]],
                                   k == lst.size() - 1});
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    timer_event_t want;
    if (rst) begin
      wheel_now = '0;
      errors <= 0;
      checked <= 0;
      events_due = {};
      foreach (filled[i]) filled[i] = 1'b0;
      foreach (armed[i]) armed[i] = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_item();
      if (out_valid && out_ready) begin
        checked <= checked + 1;
        if (events_due.size() == 0) begin
          $display("%0t unexpected result: kind %0d slot %0d data %h last %0d",
                   $time, event_kind, out_slot, out_data, last);
          errors <= errors + 1;
        end else begin
          want = events_due.pop_front();
          if (want != {event_kind, out_slot, out_data, last}) begin
            $display("%0t mismatch: expected kind %0d slot %0d data %h last %0d",
                     $time, want.kind, want.sl, want.data, want.fin);
            $display("%0t           actual   kind %0d slot %0d data %h last %0d",
                     $time, event_kind, out_slot, out_data, last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[dv/hierarchical_timer_wheel_tb.sv]
// testbench top of the timer wheel: stimulus, handshake idling and verdict
`timescale 1ns / 100ps
module hierarchical_timer_wheel_tb;
  import htw_pkg::*;

  localparam int LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [5:0]  slot = '0;
  logic [31:0] expire_time = '0;
  logic [31:0] timer_data = '0;
  logic [31:0] now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [5:0]  out_slot;
  logic [31:0] out_data;
  logic        last;
  int          errors;
  int          checked;
  int          waiting;
  int          cycles = 0;
  int          sent = 0;
  logic        calm = 1'b0;
  logic [31:0] wheel_est = '0;

  hierarchical_timer_wheel dut (.*);

  htw_checker chk (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("hierarchical_timer_wheel_tb: errors");
      $finish;
    end
  end

  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = calm ? 0 : $urandom_range(0, 7);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(htw_op_t op, logic [5:0] s, logic [31:0] e, logic [31:0] d,
                      logic [31:0] n);
    int g;
    logic [31:0] lead;
    g = calm ? 0 : $urandom_range(0, 7);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    slot <= s;
    expire_time <= e;
    timer_data <= d;
    now_time <= n;
    do @(posedge clk); while (!in_ready);
    sent++;
    lead = n - wheel_est;
    if (op == OP_TICK && !lead[31]) wheel_est = wheel_est + 32'd1;
  endtask

  task automatic arm_timer(logic [5:0] s, logic [31:0] e, logic [31:0] d);
    send(OP_ADD, s, e, d, $urandom());
  endtask

  task automatic tick(logic [31:0] n);
    send(OP_TICK, 6'($urandom_range(0, 63)), $urandom(), $urandom(), n);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int k;
    logic [31:0] e;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    arm_timer(6'd0, 32'd0, 32'hffff_ffff);
    arm_timer(6'd63, 32'hffff_ffff, 32'h0000_0000);
    arm_timer(6'd0, 32'd5, 32'h1234_5678);
    arm_timer(6'd1, 32'd255, 32'haaaa_aaaa);
    arm_timer(6'd2, 32'd256, 32'h5555_5555);
    arm_timer(6'd3, 32'd1 << 14, 32'h0f0f_0f0f);
    arm_timer(6'd4, 32'd1 << 20, 32'hf0f0_f0f0);
    arm_timer(6'd5, 32'd1 << 26, 32'h8000_0001);
    arm_timer(6'd6, 32'h7fff_ffff, 32'h0000_0001);
    arm_timer(6'd7, 32'd1, 32'h0000_0002);
    arm_timer(6'd8, 32'd1, 32'h0000_0003);
    tick(32'd0);
    tick(32'd0);
    tick(32'd1);
    tick(32'hffff_ffff);
    tick(32'd5);
    arm_timer(6'd0, 32'd1, 32'hdead_beef);
    arm_timer(6'd42, 32'h8000_0000, 32'hffff_ffff);
    tick(32'd100);
    tick(32'd100);

    // random mix
    for (k = 0; k < 70; k++) begin
      if (k == 35) drain();
      calm = (k >= 45 && k < 60);
      if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 3))
          0: e = wheel_est + $urandom_range(0, 8);
          1: e = wheel_est + $urandom_range(0, 300);
          2: e = wheel_est + $urandom_range(0, 40000);
          default: e = $urandom();
        endcase
        arm_timer(6'($urandom_range(0, 63)), e, $urandom());
      end else begin
        case ($urandom_range(0, 5))
          0: tick(wheel_est - $urandom_range(1, 5));
          1: tick($urandom());
          default: tick(wheel_est + $urandom_range(0, 3));
        endcase
      end
    end

    // near timers, then ticks that run out those due within ten ticks
    for (k = 0; k < 10; k++)
      arm_timer(6'($urandom_range(0, 63)), wheel_est + $urandom_range(0, 12), $urandom());
    for (k = 0; k < 10; k++) begin
      calm = (k < 4);
      tick(wheel_est + 32'd1000);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("sent %0d transactions, checked %0d results, wheel time %0d",
             sent, checked, wheel_est);
    $display("covered adds, rejects, past due, idle ticks, expiry runs, stalls");
    if (errors == 0 && waiting == 0) begin
      $display("hierarchical_timer_wheel_tb: clean");
    end else begin
      $display("hierarchical_timer_wheel_tb: errors");
    end
    $finish;
  end

endmodule

[hierarchical_timer_wheel.f]
src/htw_pkg.sv
src/htw_front.sv
src/htw_back.sv
src/hierarchical_timer_wheel.sv
dv/htw_checker.sv
dv/hierarchical_timer_wheel_tb.sv
